>>> rtl/core/amafir_pkg.sv
package amafir_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int FIR_W       = 32;
	localparam int MA_W        = 19;
	localparam int TAPS        = 8;
	localparam int MA_LEN      = 6;
	localparam int Q15_SHIFT   = 15;
	localparam int ABS_W       = 18;
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W      = ABS_W + RECIP_W;

	// ceil(2^20 / 6): exact floor(m / 6) for every m below 2^19
	localparam logic [RECIP_W-1:0] RECIP6 = 18'd174763;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [15:0]         coef_t;
	typedef logic signed [FIR_W-1:0]    fir_acc_t;
	typedef logic signed [MA_W-1:0]     ma_acc_t;

	typedef struct packed {
		logic shift;
	} cell_ctrl_t;

	localparam coef_t FIR_COEF [TAPS] = '{
		16'sd288, 16'sd1570, 16'sd5374, 16'sd9152,
		16'sd9152, 16'sd5374, 16'sd1570, 16'sd288
	};

endpackage

>>> rtl/core/amafir_cell.sv
module amafir_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  amafir_pkg::cell_ctrl_t ctrl,
	input  amafir_pkg::sample_t    sample,
	input  amafir_pkg::coef_t      coef,
	input  logic                   ma_tap,
	input  amafir_pkg::fir_acc_t   fir_in,
	input  amafir_pkg::ma_acc_t    ma_in,
	output amafir_pkg::fir_acc_t   fir_out,
	output amafir_pkg::ma_acc_t    ma_out
);

	amafir_pkg::fir_acc_t fir_q;
	amafir_pkg::ma_acc_t  ma_q;
	amafir_pkg::fir_acc_t prod;
	amafir_pkg::fir_acc_t fir_next;
	amafir_pkg::ma_acc_t  ma_next;

	assign prod     = amafir_pkg::FIR_W'(sample) * amafir_pkg::FIR_W'(coef);
	assign fir_next = prod + fir_in;
	assign ma_next  = ma_tap ? (ma_in + amafir_pkg::MA_W'(sample)) : '0;

	// partial sums stand for an all-zero history after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fir_q <= '0;
			ma_q  <= '0;
		end else if (ctrl.shift) begin
			fir_q <= fir_next;
			ma_q  <= ma_next;
		end
	end

	assign fir_out = fir_q;
	assign ma_out  = ma_q;

endmodule

>>> rtl/core/accel_moving_average_fir_filter.sv
// Accelerometer smoother: each accepted sample beat yields one result beat holding a
// six-sample moving average (truncated toward zero) and an eight-tap symmetric Q1.15
// low-pass FIR value (truncated toward zero). One sample is taken per clock while
// sample_ready is high; its result beat passes the final-tap, divide and output
// registers and leaves when the output is ready. The history lives in a row of seven
// transposed-form cells, each holding one FIR partial sum and one running-sum partial,
// that advance only when a sample beat is accepted; after reset they read as zero
// samples. Behind the cells sit three registered stages (final tap, divide, output)
// with per-stage valid bits, so bubbles collapse and stalls at the output back up one
// stage at a time.
module accel_moving_average_fir_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  amafir_pkg::sample_t sample,
	output logic                result_valid,
	input  logic                result_ready,
	output amafir_pkg::sample_t average_out,
	output amafir_pkg::sample_t lowpass_out
);

	amafir_pkg::fir_acc_t   fir_ps [1:amafir_pkg::TAPS];
	amafir_pkg::ma_acc_t    ma_ps  [1:amafir_pkg::TAPS];
	amafir_pkg::cell_ctrl_t ctrl;

	logic en1, en2, en3;
	logic v1_q, v2_q, v3_q;
	logic accept;

	amafir_pkg::fir_acc_t acc_d, acc_s1, lp_sum;
	amafir_pkg::ma_acc_t  ma_d, ma_s1, ma_mag;
	amafir_pkg::sample_t  lp_s2, avg_q, lp_q;
	logic [amafir_pkg::PROD_W-1:0] prod_s2;
	logic [amafir_pkg::SAMPLE_W-1:0] quot;
	logic neg_s2;

	assign en3          = !v3_q || result_ready;
	assign en2          = !v2_q || en3;
	assign en1          = !v1_q || en2;
	assign sample_ready = en1;
	assign accept       = sample_valid && sample_ready;
	assign ctrl.shift   = accept;

	assign fir_ps[amafir_pkg::TAPS] = '0;
	assign ma_ps[amafir_pkg::TAPS]  = '0;

	for (genvar k = 1; k < amafir_pkg::TAPS; k++) begin : g_cell
		amafir_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.sample  (sample),
			.coef    (amafir_pkg::FIR_COEF[k]),
			.ma_tap  (k < amafir_pkg::MA_LEN),
			.fir_in  (fir_ps[k+1]),
			.ma_in   (ma_ps[k+1]),
			.fir_out (fir_ps[k]),
			.ma_out  (ma_ps[k])
		);
	end

	// leading tap closes both sums
	assign acc_d = amafir_pkg::FIR_W'(sample) * amafir_pkg::FIR_W'(amafir_pkg::FIR_COEF[0])
		+ fir_ps[1];
	assign ma_d  = amafir_pkg::MA_W'(sample) + ma_ps[1];

	// bias negatives so the shift truncates toward zero
	assign lp_sum = acc_s1 + (acc_s1[amafir_pkg::FIR_W-1] ? 32'sd32767 : 32'sd0);
	assign ma_mag = ma_s1[amafir_pkg::MA_W-1] ? -ma_s1 : ma_s1;
	assign quot   = prod_s2[amafir_pkg::RECIP_SHIFT +: amafir_pkg::SAMPLE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) v1_q <= accept;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && accept) begin
			acc_s1 <= acc_d;
			ma_s1  <= ma_d;
		end
		if (en2 && v1_q) begin
			lp_s2   <= lp_sum[amafir_pkg::Q15_SHIFT +: amafir_pkg::SAMPLE_W];
			neg_s2  <= ma_s1[amafir_pkg::MA_W-1];
			prod_s2 <= amafir_pkg::PROD_W'(ma_mag[amafir_pkg::ABS_W-1:0])
				* amafir_pkg::PROD_W'(amafir_pkg::RECIP6);
		end
		if (en3 && v2_q) begin
			avg_q <= neg_s2 ? -amafir_pkg::sample_t'(quot) : amafir_pkg::sample_t'(quot);
			lp_q  <= lp_s2;
		end
	end

	assign result_valid = v3_q;
	assign average_out  = avg_q;
	assign lowpass_out  = lp_q;

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v1_q)
		else $error("accepted sample beat did not reach stage one");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && !en2) |=> (v1_q && $stable(acc_s1) && $stable(ma_s1)))
		else $error("stage one lost its contents while stalled");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(v2_q))
		else $error("result beat appeared without a stage two item");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && v2_q && v3_q && !result_ready) |-> !sample_ready)
		else $error("sample taken with every stage full and output stalled");

endmodule
